>>> design/cce_pkg.sv
// cce_pkg: shared types, character constants and byte tables for the color code expander.
// No dependencies; used by the front, queue and back modules.

package cce_pkg;

  // characters of the marker and escape sequences
  localparam logic [7:0] BarChar  = 8'h7C;
  localparam logic [7:0] EscChar  = 8'h1B;
  localparam logic [7:0] LbrChar  = 8'h5B;
  localparam logic [7:0] SemiChar = 8'h3B;
  localparam logic [7:0] ZeroChar = 8'h30;
  localparam logic [7:0] OneChar  = 8'h31;
  localparam logic [7:0] ThreeChar = 8'h33;
  localparam logic [7:0] MChar    = 8'h6D;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // what the back end has to emit for one input byte
  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,  // the byte alone
    OP_BAR_BYTE = 2'd1,  // a bar, then the byte
    OP_ESC      = 2'd2   // an ansi escape sequence
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_reset;  // 'x' code: ESC [ 0 ; 0 m
    logic       bright;
    logic [2:0] hue;
    logic       msg_end;
  } cmd_t;

  typedef struct packed {
    logic       is_code;
    logic       is_reset;
    logic       bright;
    logic [2:0] hue;
  } code_t;

  // code letter lookup
  function automatic code_t classify(logic [7:0] b);
    code_t c;
    c = '0;
    c.is_code = 1'b1;
    case (b)
      8'h78: c.is_reset = 1'b1;           // x
      8'h6C: c.hue = 3'd0;                // l
      8'h72: c.hue = 3'd1;                // r
      8'h67: c.hue = 3'd2;                // g
      8'h79: c.hue = 3'd3;                // y
      8'h62: c.hue = 3'd4;                // b
      8'h6D: c.hue = 3'd5;                // m
      8'h63: c.hue = 3'd6;                // c
      8'h77: c.hue = 3'd7;                // w
      8'h4C: begin c.hue = 3'd0; c.bright = 1'b1; end
      8'h52: begin c.hue = 3'd1; c.bright = 1'b1; end
      8'h47: begin c.hue = 3'd2; c.bright = 1'b1; end
      8'h59: begin c.hue = 3'd3; c.bright = 1'b1; end
      8'h42: begin c.hue = 3'd4; c.bright = 1'b1; end
      8'h4D: begin c.hue = 3'd5; c.bright = 1'b1; end
      8'h43: begin c.hue = 3'd6; c.bright = 1'b1; end
      8'h57: begin c.hue = 3'd7; c.bright = 1'b1; end
      default: c.is_code = 1'b0;
    endcase
    return c;
  endfunction

  // number of bytes a command emits
  function automatic logic [2:0] cmd_len(cmd_t c);
    logic [2:0] n;
    case (c.op)
      OP_BYTE:     n = 3'd1;
      OP_BAR_BYTE: n = 3'd2;
      OP_ESC:      n = c.is_reset ? 3'd6 : 3'd7;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  // byte number idx of a command's expansion
  function automatic logic [7:0] cmd_byte(cmd_t c, logic [2:0] idx);
    logic [7:0] r;
    r = c.data;
    case (c.op)
      OP_BYTE:     r = c.data;
      OP_BAR_BYTE: r = (idx == 3'd0) ? BarChar : c.data;
      OP_ESC: begin
        case (idx)
          3'd0: r = EscChar;
          3'd1: r = LbrChar;
          3'd2: r = (c.bright && !c.is_reset) ? OneChar : ZeroChar;
          3'd3: r = SemiChar;
          3'd4: r = c.is_reset ? ZeroChar : ThreeChar;
          3'd5: r = c.is_reset ? MChar : (ZeroChar | {5'd0, c.hue});
          default: r = MChar;
        endcase
      end
      default: r = c.data;
    endcase
    return r;
  endfunction

endpackage

>>> design/color_code_expander.sv
// color_code_expander: top level, wires the front end, command queue and back end.
// Depends on cce_pkg, cce_front, cce_queue and cce_back.
//
// Usage:
//   Input stream s_axis: tdata is a text byte, tlast marks the end of a message.
//   Output stream m_axis: tdata is a rewritten byte, tlast marks the last byte
//   caused by one input byte, tuser marks that byte when its input ended a message.
//   Config channel cfg: one write sets color_enable from cfg_data_i; cfg_ready_o
//   is always high. Write it only while the block is idle.
// Timing:
//   An input byte is classified in the cycle it transfers and queued; the back
//   end loads its first output byte from the queue head into the output
//   register. Throughput is one output byte per cycle while m_axis_tready is
//   high. A plain byte gives 1 output byte, a bar pair 2, an escape 6 or 7; input
//   that produces nothing is not queued. The back end's one-byte-per-cycle
//   expansion sets the rate; a two-entry queue lets input run on while it works.
// Reset: the pending marker, queue and output valid clear, color_enable is 0.
// Stall: when m_axis_tready is low the output register holds, the queue fills
//   and s_axis_tready falls once both entries are taken.

module color_code_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // color_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // message_done
);

  logic          color_q;
  logic          q_full, q_empty, push, pop;
  cce_pkg::cmd_t push_cmd, head;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
    end else if (cfg_valid_i) begin
      color_q <= cfg_data_i;
    end
  end

  cce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .color_en_i    (color_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  cce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  cce_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> design/cce_front.sv
// cce_front: accepts input bytes, tracks the pending marker and classifies each byte
// into an emit command. Depends on cce_pkg.

module cce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              color_en_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // in_byte
  input  logic              s_axis_tlast,   // message_end
  input  logic              q_full_i,
  output logic              push_o,
  output cce_pkg::cmd_t     push_cmd_o
);

  logic           pending_q, pending_d;
  logic           accept;
  logic           emit;
  cce_pkg::code_t code;

  assign s_axis_tready = ~q_full_i;
  assign accept        = s_axis_tvalid & ~q_full_i;
  assign code          = cce_pkg::classify(s_axis_tdata);

  // classify the byte against the marker state
  always_comb begin
    emit                = 1'b0;
    pending_d           = pending_q;
    push_cmd_o          = '0;
    push_cmd_o.op       = cce_pkg::OP_BYTE;
    push_cmd_o.data     = s_axis_tdata;
    push_cmd_o.is_reset = code.is_reset;
    push_cmd_o.bright   = code.bright;
    push_cmd_o.hue      = code.hue;
    push_cmd_o.msg_end  = s_axis_tlast;
    if (!pending_q) begin
      if (s_axis_tdata == cce_pkg::BarChar) begin
        if (s_axis_tlast) begin
          emit = color_en_i;
        end else begin
          pending_d = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end
    end else begin
      pending_d = 1'b0;
      if (s_axis_tdata == cce_pkg::BarChar) begin
        emit = 1'b1;
      end else if (!code.is_code) begin
        emit          = 1'b1;
        push_cmd_o.op = cce_pkg::OP_BAR_BYTE;
      end else if (color_en_i) begin
        emit          = 1'b1;
        push_cmd_o.op = cce_pkg::OP_ESC;
      end
    end
    if (s_axis_tlast) begin
      pending_d = 1'b0;
    end
  end

  assign push_o = accept & emit;

  // marker state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
    end
  end

endmodule

>>> design/cce_queue.sv
// cce_queue: short command queue between the front and back ends.
// Depends on cce_pkg for the command type and depth.

module cce_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  cce_pkg::cmd_t           push_cmd_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output cce_pkg::cmd_t           head_o
);

  cce_pkg::cmd_t                  mem_q [cce_pkg::QDepth];
  logic [cce_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [cce_pkg::QCntW-1:0]      count_q;

  assign full_o  = (count_q == cce_pkg::QCntW'(cce_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == cce_pkg::QPtrW'(cce_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == cce_pkg::QPtrW'(cce_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> design/cce_back.sv
// cce_back: expands queued commands into an output register, one byte per cycle unless stalled.
// Depends on cce_pkg for the command type and expansion tables.

module cce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  cce_pkg::cmd_t     head_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_byte
  output logic              m_axis_tlast,   // run_last
  output logic              m_axis_tuser    // message_done
);

  cce_pkg::cmd_t cur_q;
  logic [2:0]    idx_q;
  logic          busy_q;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          out_last_q, out_user_q;

  cce_pkg::cmd_t src_cmd;
  logic [2:0]    src_idx;
  logic          slot_free, have, load, last;

  // pick the byte source: command in progress or queue head
  assign slot_free = ~out_valid_q | m_axis_tready;
  assign have      = busy_q | ~q_empty_i;
  assign load      = slot_free & have;
  assign pop_o     = slot_free & ~busy_q & ~q_empty_i;
  assign src_cmd   = busy_q ? cur_q : head_i;
  assign src_idx   = busy_q ? idx_q : 3'd0;
  assign last      = (src_idx == cce_pkg::cmd_len(src_cmd) - 3'd1);

  // expansion step and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= cce_pkg::cmd_byte(src_cmd, src_idx);
      out_last_q <= last;
      out_user_q <= last & src_cmd.msg_end;
      cur_q      <= src_cmd;
      idx_q      <= src_idx + 3'd1;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= have;
      busy_q      <= have & ~last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> design/cce_checker.sv
// cce_checker: port-level assertions for color_code_expander, bound to the top level.
// Depends only on the top level's ports.

module cce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // message done only on the last byte of a run
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("message_done without run_last");

  // a run continues without a gap once started
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside an output run");

  // an escape that opens a run is followed by its bracket
  a_esc_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tdata == 8'h1B)
    |=> (m_axis_tvalid && m_axis_tdata == 8'h5B))
    else $error("escape not followed by bracket");

  // stalled output transfer holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");

endmodule

bind color_code_expander cce_checker u_cce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
